FILE: design/ffc_pkg.sv
// Package for the frame freshness checker.
// Types, codes and widths shared by the controller, the datapath and the top level.
// No dependencies.
package ffc_pkg;

    localparam int SAMPLES_DEF        = 16;
    localparam int FRAME_LEN_BITS_DEF = 24;

    localparam int TIME_W    = 48;
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int FRAMES_W  = 2;
    localparam int MOTION_W  = 6;
    localparam int OUT_W     = 16;

    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_BYTE   = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_PASS = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FAIL = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SAME = 2'd2;

    localparam logic [FRAMES_W-1:0] FRAMES_PER_CHECK = 2'd3;
    localparam logic [FRAMES_W-1:0] LAST_FRAME       = 2'd2;
    localparam logic [FRAMES_W-1:0] FIRST_FRAME      = 2'd0;
    localparam logic [FRAMES_W-1:0] SECOND_FRAME     = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BYTES,
        ST_ZERO
    } t_state;

    typedef struct packed {
        logic hdr_ok;
        logic fail;
        logic store;
        logic store_zero;
        logic byte_take;
        logic frame_done;
    } t_cmd;

    typedef struct packed {
        logic hdr_bad;
        logic len_zero;
        logic smp_match;
        logic smp_more;
        logic last_byte;
        logic last_sample;
        logic frame_last;
        logic out_full;
    } t_sts;

endpackage

FILE: design/ffc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ffc_ctrl.sv
// Controller of the frame freshness checker: header, byte and zero-fill phases.
// Depends on ffc_pkg; drives the datapath through ffc_pkg::t_cmd.
module ffc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_req_type,
    output logic           o_ready,
    input  ffc_pkg::t_sts  i_sts,
    output ffc_pkg::t_cmd  o_cmd
);

    ffc_pkg::t_state r_state;
    ffc_pkg::t_state n_state;
    logic            take_byte;
    logic            zero_go;

    // a byte is taken once no more samples map onto it and no held result blocks it
    assign take_byte = !i_sts.smp_more &&
                       !(i_sts.last_byte && i_sts.frame_last && i_sts.out_full);
    assign zero_go   = !(i_sts.last_sample && i_sts.frame_last && i_sts.out_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffc_pkg::ST_IDLE: begin
                if (i_valid && i_req_type == ffc_pkg::REQ_HEADER && !i_sts.hdr_bad) begin
                    n_state = i_sts.len_zero ? ffc_pkg::ST_ZERO : ffc_pkg::ST_BYTES;
                end
            end
            ffc_pkg::ST_BYTES: begin
                if (i_valid && i_req_type == ffc_pkg::REQ_BYTE && take_byte &&
                    i_sts.last_byte) begin
                    n_state = ffc_pkg::ST_IDLE;
                end
            end
            ffc_pkg::ST_ZERO: begin
                if (zero_go && i_sts.last_sample) begin
                    n_state = ffc_pkg::ST_IDLE;
                end
            end
            default: n_state = ffc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ffc_pkg::ST_IDLE: begin
                if (i_req_type == ffc_pkg::REQ_HEADER && i_sts.hdr_bad) begin
                    o_ready   = !i_sts.out_full;
                    o_cmd.fail = i_valid && !i_sts.out_full;
                end else begin
                    o_ready     = 1'b1;
                    o_cmd.hdr_ok = i_valid && i_req_type == ffc_pkg::REQ_HEADER;
                end
            end
            ffc_pkg::ST_BYTES: begin
                if (i_req_type == ffc_pkg::REQ_HEADER) begin
                    o_ready = 1'b1;
                end else begin
                    o_ready          = take_byte;
                    o_cmd.store      = i_valid && i_sts.smp_match &&
                                       (i_sts.smp_more || take_byte);
                    o_cmd.byte_take  = i_valid && take_byte;
                    o_cmd.frame_done = i_valid && take_byte && i_sts.last_byte;
                end
            end
            ffc_pkg::ST_ZERO: begin
                o_cmd.store      = zero_go;
                o_cmd.store_zero = 1'b1;
                o_cmd.frame_done = zero_go && i_sts.last_sample;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_zero_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ffc_pkg::ST_ZERO |-> !o_ready)
        else $error("input taken during zero fill");
    a_zero_len_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.hdr_ok && i_sts.len_zero) |=> r_state == ffc_pkg::ST_ZERO)
        else $error("zero-length frame skipped fill");
`endif

endmodule

FILE: design/ffc_dp.sv
// Datapath of the frame freshness checker: sample positions, signature memory,
// difference counters, capture-time checks and the result register.
// Depends on ffc_pkg and ffc_ram.
module ffc_dp #(
    parameter int SAMPLES        = ffc_pkg::SAMPLES_DEF,
    parameter int FRAME_LEN_BITS = ffc_pkg::FRAME_LEN_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffc_pkg::t_cmd                   i_cmd,
    output ffc_pkg::t_sts                   o_sts,
    input  logic                            i_present,
    input  logic [FRAME_LEN_BITS-1:0]       i_len,
    input  logic [ffc_pkg::TIME_W-1:0]      i_t0,
    input  logic [ffc_pkg::TIME_W-1:0]      i_t1,
    input  logic [ffc_pkg::BYTE_W-1:0]      i_byte,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ffc_pkg::VERDICT_W-1:0]   o_verdict,
    output logic [ffc_pkg::FRAMES_W-1:0]    o_frames,
    output logic [ffc_pkg::MOTION_W-1:0]    o_motion,
    output logic                            o_fresh
);

    localparam int FLB   = FRAME_LEN_BITS;
    localparam int KW    = $clog2(SAMPLES + 1);
    localparam int AW    = $clog2(SAMPLES);
    localparam int ACC_W = FLB + KW;
    localparam int CNT_W = $clog2(SAMPLES + 2);
    localparam int SUM_W = CNT_W + ffc_pkg::MOTION_W + 1;

    logic [ffc_pkg::FRAMES_W-1:0]  r_frame, n_frame;
    logic [FLB-1:0]                r_bp, n_bp;
    logic [KW-1:0]                 r_k, n_k;
    logic [FLB-1:0]                r_lm1, n_lm1;
    logic [FLB-1:0]                r_len, n_len;
    logic [FLB-1:0]                r_prev_len, n_prev_len;
    logic [CNT_W-1:0]              r_cf, n_cf;
    logic [CNT_W-1:0]              r_cs, n_cs;
    logic [ffc_pkg::TIME_W-1:0]    r_last_end, n_last_end;
    logic                          r_have, n_have;
    logic [ACC_W-1:0]              r_acc, n_acc;
    logic [ACC_W-1:0]              r_acc_nx, n_acc_nx;
    logic [ACC_W-1:0]              r_thr, n_thr;
    logic                          r_out_valid, n_out_valid;
    logic [ffc_pkg::VERDICT_W-1:0] r_verdict, n_verdict;
    logic [ffc_pkg::FRAMES_W-1:0]  r_frames, n_frames;
    logic [ffc_pkg::MOTION_W-1:0]  r_motion, n_motion;
    logic                          r_fresh, n_fresh;

    logic [ffc_pkg::BYTE_W-1:0]    wdata;
    logic [ffc_pkg::BYTE_W-1:0]    rdata;
    logic                          diff;
    logic                          emit;
    logic [SUM_W-1:0]              sum;

    assign wdata = i_cmd.store_zero ? '0 : i_byte;

    ffc_ram #(
        .WIDTH (ffc_pkg::BYTE_W),
        .DEPTH (SAMPLES)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_k[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_k[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.hdr_bad     = !i_present || (i_t1 <= i_t0) || (r_have && i_t1 <= r_last_end);
        o_sts.len_zero    = (i_len == '0);
        o_sts.smp_match   = (r_k < KW'(SAMPLES)) && (r_acc <= r_thr);
        o_sts.smp_more    = o_sts.smp_match && (r_k < KW'(SAMPLES - 1)) &&
                            (r_acc_nx <= r_thr);
        o_sts.last_byte   = (r_bp == r_lm1);
        o_sts.last_sample = (r_k == KW'(SAMPLES - 1));
        o_sts.frame_last  = (r_frame == ffc_pkg::LAST_FRAME);
        o_sts.out_full    = r_out_valid && !i_out_ready;
    end

    // a difference counts once per sample, or once per length mismatch
    assign diff = (r_frame != ffc_pkg::FIRST_FRAME) &&
                  ((i_cmd.hdr_ok && r_prev_len != i_len) ||
                   (i_cmd.store && rdata != wdata));
    assign emit = i_cmd.fail || (i_cmd.frame_done && r_frame == ffc_pkg::LAST_FRAME);

    always_comb begin
        n_frame     = r_frame;
        n_bp        = r_bp;
        n_k         = r_k;
        n_lm1       = r_lm1;
        n_len       = r_len;
        n_prev_len  = r_prev_len;
        n_cf        = r_cf;
        n_cs        = r_cs;
        n_last_end  = r_last_end;
        n_have      = r_have;
        n_acc       = r_acc;
        n_acc_nx    = r_acc_nx;
        n_thr       = r_thr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_verdict   = r_verdict;
        n_frames    = r_frames;
        n_motion    = r_motion;
        n_fresh     = r_fresh;

        if (diff && r_frame == ffc_pkg::SECOND_FRAME) begin
            n_cf = r_cf + CNT_W'(1);
        end
        if (diff && r_frame == ffc_pkg::LAST_FRAME) begin
            n_cs = r_cs + CNT_W'(1);
        end
        sum = SUM_W'(n_cf) + SUM_W'(n_cs);

        if (i_cmd.hdr_ok) begin
            n_last_end = i_t1;
            n_have     = 1'b1;
            n_bp       = '0;
            n_k        = '0;
            n_len      = i_len;
            n_lm1      = i_len - FLB'(1);
            n_acc      = '0;
            n_acc_nx   = ACC_W'(i_len - FLB'(1));
            n_thr      = ACC_W'(SAMPLES - 2);
        end
        if (i_cmd.store) begin
            n_k      = r_k + KW'(1);
            n_acc    = r_acc_nx;
            n_acc_nx = r_acc_nx + ACC_W'(r_lm1);
        end
        if (i_cmd.byte_take) begin
            n_bp  = r_bp + FLB'(1);
            n_thr = r_thr + ACC_W'(SAMPLES - 1);
        end
        if (i_cmd.frame_done) begin
            n_prev_len = r_len;
            n_frame    = r_frame + ffc_pkg::FRAMES_W'(1);
        end

        if (emit) begin
            n_out_valid = 1'b1;
            if (i_cmd.fail) begin
                n_verdict = ffc_pkg::VERDICT_FAIL;
                n_frames  = r_frame;
                n_motion  = '0;
                n_fresh   = 1'b0;
            end else begin
                n_verdict = (n_cf == '0 && n_cs == '0) ? ffc_pkg::VERDICT_SAME
                                                       : ffc_pkg::VERDICT_PASS;
                n_frames  = ffc_pkg::FRAMES_PER_CHECK;
                n_motion  = sum[ffc_pkg::MOTION_W-1:0];
                n_fresh   = !(n_cf == '0 && n_cs == '0);
            end
            // new check
            n_frame    = ffc_pkg::FIRST_FRAME;
            n_prev_len = '0;
            n_len      = '0;
            n_cf       = '0;
            n_cs       = '0;
            n_last_end = '0;
            n_have     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= ffc_pkg::FIRST_FRAME;
            r_bp        <= '0;
            r_k         <= '0;
            r_len       <= '0;
            r_prev_len  <= '0;
            r_cf        <= '0;
            r_cs        <= '0;
            r_last_end  <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_frame     <= n_frame;
            r_bp        <= n_bp;
            r_k         <= n_k;
            r_len       <= n_len;
            r_prev_len  <= n_prev_len;
            r_cf        <= n_cf;
            r_cs        <= n_cs;
            r_last_end  <= n_last_end;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lm1     <= n_lm1;
        r_acc     <= n_acc;
        r_acc_nx  <= n_acc_nx;
        r_thr     <= n_thr;
        r_verdict <= n_verdict;
        r_frames  <= n_frames;
        r_motion  <= n_motion;
        r_fresh   <= n_fresh;
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_frames    = r_frames;
    assign o_motion    = r_motion;
    assign o_fresh     = r_fresh;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !(r_out_valid && !i_out_ready))
        else $error("result overwritten while stalled");
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame != ffc_pkg::FRAMES_PER_CHECK)
        else $error("frame number out of range");
    a_check_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_frame == ffc_pkg::FIRST_FRAME && !r_have && o_out_valid))
        else $error("check did not restart after result");
    a_sample_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> r_k < KW'(SAMPLES))
        else $error("sample index past end");
`endif

endmodule

FILE: design/frame_freshness_checker.sv
// Frame freshness checker, top level.
// Unpacks the input stream words, joins ffc_ctrl and ffc_dp; depends on ffc_pkg.
//
// Input channel (s_axis): tuser 0 is a frame header (present flag, length, capture
// start and end times), tuser 1 carries one frame byte. Three frames form one check.
// Output channel (m_axis): one word per check, sent after the third frame or at once
// when a header shows a missing frame or non-increasing capture times.
// Throughput: a header or a byte is taken one per cycle, but for the holds below.
// Samples are written one per cycle through the single write port of the signature
// memory, so a byte carrying more than one sample position is held until all are
// written (only in frames shorter than SAMPLES), and a zero-length frame holds the
// input while its zero fill writes every sample. The result word appears in the
// cycle after the word completing the check, or after a zero-length frame's fill.
// The result sits in an output register; input keeps flowing while it waits, and only
// a word that would produce a second result is held until the first is taken.
// Reset (synchronous, active low) starts a fresh check with no pending result; the
// signature memory is not cleared, since the first frame of each check writes it
// before any compare reads it.
module frame_freshness_checker #(
    parameter int SAMPLES        = ffc_pkg::SAMPLES_DEF,
    parameter int FRAME_LEN_BITS = ffc_pkg::FRAME_LEN_BITS_DEF,
    localparam int IN_BITS       = 1 + FRAME_LEN_BITS + 2 * ffc_pkg::TIME_W + ffc_pkg::BYTE_W,
    localparam int IN_W          = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // frame_present, frame_len, capture_start, capture_end, pixel_byte
    input  logic [IN_W-1:0]          i_s_axis_tdata,
    // req_type
    input  logic                     i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // verdict, frames_captured, motion_samples, fresh_sequence
    output logic [ffc_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int LEN_LO   = 1;
    localparam int START_LO = LEN_LO + FRAME_LEN_BITS;
    localparam int END_LO   = START_LO + ffc_pkg::TIME_W;
    localparam int BYTE_LO  = END_LO + ffc_pkg::TIME_W;
    localparam int PAD_W    = ffc_pkg::OUT_W - ffc_pkg::VERDICT_W - ffc_pkg::FRAMES_W
                              - ffc_pkg::MOTION_W - 1;

    ffc_pkg::t_cmd                 cmd;
    ffc_pkg::t_sts                 sts;
    logic [ffc_pkg::VERDICT_W-1:0] verdict;
    logic [ffc_pkg::FRAMES_W-1:0]  frames;
    logic [ffc_pkg::MOTION_W-1:0]  motion;
    logic                          fresh;

    ffc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser),
        .o_ready    (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffc_dp #(
        .SAMPLES        (SAMPLES),
        .FRAME_LEN_BITS (FRAME_LEN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_present   (i_s_axis_tdata[0]),
        .i_len       (i_s_axis_tdata[START_LO-1:LEN_LO]),
        .i_t0        (i_s_axis_tdata[END_LO-1:START_LO]),
        .i_t1        (i_s_axis_tdata[BYTE_LO-1:END_LO]),
        .i_byte      (i_s_axis_tdata[BYTE_LO+ffc_pkg::BYTE_W-1:BYTE_LO]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_verdict   (verdict),
        .o_frames    (frames),
        .o_motion    (motion),
        .o_fresh     (fresh)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, fresh, motion, frames, verdict};

endmodule

FILE: tb/sv/frame_freshness_checker_test.sv
// Testbench for frame_freshness_checker: directed and random three-frame checks
// with random stalls on both stream sides, scored against an in-bench predictor.
// Depends on ffc_pkg and the frame_freshness_checker RTL.
`timescale 1ns / 100ps

module frame_freshness_checker_test;

    localparam int SMP         = ffc_pkg::SAMPLES_DEF;
    localparam int LEN_W       = ffc_pkg::FRAME_LEN_BITS_DEF;
    localparam int TIME_W      = ffc_pkg::TIME_W;
    localparam int BYTE_W      = ffc_pkg::BYTE_W;
    localparam int MOTION_W    = ffc_pkg::MOTION_W;
    localparam int FRAMES_W    = ffc_pkg::FRAMES_W;
    localparam int VERDICT_W   = ffc_pkg::VERDICT_W;
    localparam int OUT_W       = ffc_pkg::OUT_W;
    localparam int IN_BITS     = 1 + LEN_W + 2 * TIME_W + BYTE_W;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_PAD      = IN_W - IN_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 750;

    typedef struct packed {
        logic              req;
        logic              present;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic [BYTE_W-1:0] pix;
    } t_in_word;

    typedef struct packed {
        logic                 fresh;
        logic [MOTION_W-1:0]  motion;
        logic [FRAMES_W-1:0]  frames;
        logic [VERDICT_W-1:0] verdict;
    } t_verdict_word;

    class freshness_scoreboard;
        logic [FRAMES_W-1:0] frame_no;
        logic [LEN_W-1:0]    byte_pos;
        int unsigned         next_smp;
        logic [BYTE_W-1:0]   sig[SMP];
        logic [LEN_W-1:0]    prev_len;
        logic [LEN_W-1:0]    cur_len;
        logic [4:0]          chg_a;
        logic [4:0]          chg_b;
        logic [TIME_W-1:0]   last_end;
        logic                have_end;
        t_verdict_word       verdict_q[$];
        int                  errors;

        function new();
            foreach (sig[k]) sig[k] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            frame_no = ffc_pkg::FIRST_FRAME;
            byte_pos = '0;
            next_smp = 0;
            prev_len = '0;
            cur_len  = '0;
            chg_a    = '0;
            chg_b    = '0;
            last_end = '0;
            have_end = 1'b0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void queue_verdict(logic [VERDICT_W-1:0] v, logic [FRAMES_W-1:0] f,
                                    logic [MOTION_W-1:0] m, logic fr);
            t_verdict_word r;
            r.verdict = v;
            r.frames  = f;
            r.motion  = m;
            r.fresh   = fr;
            verdict_q.push_back(r);
        endfunction

        function void bump();
            if (frame_no == ffc_pkg::SECOND_FRAME)
                chg_a++;
            else if (frame_no == ffc_pkg::LAST_FRAME)
                chg_b++;
        endfunction

        function void put_sample(int unsigned k, logic [BYTE_W-1:0] v);
            if (k >= SMP)
                return;
            if (frame_no != ffc_pkg::FIRST_FRAME && sig[k] != v)
                bump();
            sig[k] = v;
        endfunction

        function logic [63:0] smp_pos(int unsigned k, logic [LEN_W-1:0] len);
            return (64'(k) * 64'(len - 1'b1)) / 64'(SMP - 1);
        endfunction

        function void close_frame();
            logic [MOTION_W-1:0] motion;
            prev_len = cur_len;
            cur_len  = '0;
            byte_pos = '0;
            next_smp = 0;
            frame_no++;
            if (frame_no != ffc_pkg::FRAMES_PER_CHECK)
                return;
            motion = MOTION_W'(chg_a) + MOTION_W'(chg_b);
            if (chg_a == 0 && chg_b == 0)
                queue_verdict(ffc_pkg::VERDICT_SAME, ffc_pkg::FRAMES_PER_CHECK, motion, 1'b0);
            else
                queue_verdict(ffc_pkg::VERDICT_PASS, ffc_pkg::FRAMES_PER_CHECK, motion, 1'b1);
            restart();
        endfunction

        function void note_word(t_in_word w);
            if (w.req == ffc_pkg::REQ_HEADER) begin
                if (cur_len != 0)
                    return;
                if (!w.present || w.t1 <= w.t0 || (have_end && w.t1 <= last_end)) begin
                    queue_verdict(ffc_pkg::VERDICT_FAIL, frame_no, '0, 1'b0);
                    restart();
                    return;
                end
                last_end = w.t1;
                have_end = 1'b1;
                if (frame_no != ffc_pkg::FIRST_FRAME && prev_len != w.len)
                    bump();
                byte_pos = '0;
                next_smp = 0;
                cur_len  = w.len;
                if (w.len == 0) begin
                    for (int k = 0; k < SMP; k++)
                        put_sample(k, '0);
                    close_frame();
                end
                return;
            end
            if (cur_len == 0)
                return;
            while (next_smp < SMP && smp_pos(next_smp, cur_len) == 64'(byte_pos)) begin
                put_sample(next_smp, w.pix);
                next_smp++;
            end
            byte_pos++;
            if (byte_pos >= cur_len)
                close_frame();
        endfunction

        task report(string msg);
            $display("%0t ERROR: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] d);
            t_verdict_word got;
            t_verdict_word want;
            got = d[$bits(t_verdict_word)-1:0];
            if (verdict_q.size() == 0) begin
                report($sformatf("result word %h with nothing expected", d));
                return;
            end
            want = verdict_q.pop_front();
            if (got.verdict !== want.verdict)
                report($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
            if (got.frames !== want.frames)
                report($sformatf("frames_captured %0d, want %0d", got.frames, want.frames));
            if (got.motion !== want.motion)
                report($sformatf("motion_samples %0d, want %0d", got.motion, want.motion));
            if (got.fresh !== want.fresh)
                report($sformatf("fresh_sequence %0d, want %0d", got.fresh, want.fresh));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata;
    logic                 i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_W-1:0]     o_m_axis_tdata;

    freshness_scoreboard sb;
    logic                calm;
    int                  n_useful;
    int                  idle_cycles;

    frame_freshness_checker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TIME_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int pick_gap(int longest);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, longest);
    endfunction

    function automatic t_in_word mk_header(logic present, logic [LEN_W-1:0] len,
                                           logic [TIME_W-1:0] t0, logic [TIME_W-1:0] t1);
        t_in_word w;
        w.req     = ffc_pkg::REQ_HEADER;
        w.present = present;
        w.len     = len;
        w.t0      = t0;
        w.t1      = t1;
        w.pix     = 8'($urandom);
        return w;
    endfunction

    function automatic t_in_word mk_byte(logic [BYTE_W-1:0] pix);
        t_in_word w;
        w.req     = ffc_pkg::REQ_BYTE;
        w.present = 1'($urandom);
        w.len     = LEN_W'($urandom);
        w.t0      = rand48();
        w.t1      = rand48();
        w.pix     = pix;
        return w;
    endfunction

    task automatic send(t_in_word w);
        int gap;
        gap = pick_gap(30);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= w.req;
        i_s_axis_tdata  <= {{IN_PAD{1'b0}}, w.pix, w.t1, w.t0, w.len, w.present};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one check: mostly three well-formed frames, sometimes a failing header or noise
    task automatic random_check();
        logic [BYTE_W-1:0] img[$];
        logic [TIME_W-1:0] t, t0, t1;
        int                style, r, len, kind;
        style = $urandom_range(0, 9);
        calm  = ($urandom_range(0, 7) == 0);
        t     = {1'b0, 15'($urandom), 32'($urandom)};
        for (int f = 0; f < 3; f++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                kind = $urandom_range(0, 2);
                if (kind == 2 && f == 0)
                    kind = 1;
                if (kind == 0) begin
                    send(mk_header(1'b0, LEN_W'($urandom), rand48(), rand48()));
                end else if (kind == 1) begin
                    t0 = rand48();
                    t1 = (t0 > 3) ? t0 - $urandom_range(0, 3) : '0;
                    send(mk_header(1'b1, LEN_W'($urandom), t0, t1));
                end else begin
                    t1 = t - $urandom_range(0, 3);
                    send(mk_header(1'b1, LEN_W'($urandom), t1 >> 1, t1));
                end
                n_useful++;
                return;
            end
            if (r < 14)
                send(mk_byte(8'($urandom)));
            if (f == 0 || style >= 5) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    len = 0;
                else if (r < 50)
                    len = $urandom_range(1, 15);
                else if (r < 93)
                    len = $urandom_range(16, 32);
                else
                    len = $urandom_range(33, 150);
                if (f > 0 && $urandom_range(0, 1) == 1)
                    len = img.size();
                img.delete();
                repeat (len) img.push_back(8'($urandom));
            end else if (style >= 3) begin
                if ($urandom_range(0, 3) == 0)
                    img.push_back(8'($urandom));
                else if (img.size() > 0)
                    img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
            end
            t0 = t + $urandom_range(0, 1000);
            t1 = t0 + 1 + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5000));
            t  = t1;
            send(mk_header(1'b1, LEN_W'(img.size()), t0, t1));
            n_useful++;
            foreach (img[i]) begin
                if ($urandom_range(0, 49) == 0)
                    send(mk_header(1'($urandom), LEN_W'($urandom), rand48(), rand48()));
                send(mk_byte(img[i]));
                n_useful++;
            end
        end
    endtask

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            int stall;
            stall = pick_gap(40);
            if (stall > 0) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        sb              = new();
        calm            = 1'b0;
        n_useful        = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ffc_pkg::REQ_HEADER;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stray word, missing frame, equal capture times
        send(mk_byte(8'hA5));
        send(mk_header(1'b0, '1, rand48(), rand48()));
        send(mk_header(1'b1, '1, 48'h123, 48'h123));
        // three empty frames up to the top of the time range: identical
        send(mk_header(1'b1, '0, '0, 48'd1));
        send(mk_header(1'b1, '0, 48'd2, 48'h7FFF_FFFF_FFFF));
        send(mk_header(1'b1, '0, 48'hFFFF_FFFF_FFFE, '1));
        // one-byte and two-byte frames, every sample differs: largest count
        send(mk_header(1'b1, 24'd1, 48'd10, 48'd20));
        send(mk_byte(8'h00));
        send(mk_header(1'b1, 24'd2, 48'd30, 48'd40));
        send(mk_header(1'b1, '1, rand48(), rand48()));
        send(mk_byte(8'hFF));
        send(mk_byte(8'hFF));
        send(mk_header(1'b1, 24'd1, 48'd50, 48'd60));
        send(mk_byte(8'h00));
        // end time not past the previous frame
        send(mk_header(1'b1, '0, 48'd100, 48'd200));
        send(mk_header(1'b1, '0, 48'd150, 48'd200));
        // end before start on the third frame
        send(mk_header(1'b1, '0, 48'd5, 48'd6));
        send(mk_header(1'b1, '0, 48'd7, 48'd8));
        send(mk_header(1'b1, '0, 48'd9, 48'd3));
        wait_drained();

        for (int n = 0; n_useful < ITEM_TARGET; n++) begin
            random_check();
            if (n % 8 == 7)
                wait_drained();
        end
        calm = 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
